### sv/smrf_pkg.sv
// ----------------------------------------------------------------------------
// smrf_pkg
// Shared types, widths and codes for the square matrix rotate and flip block.
// ----------------------------------------------------------------------------
package smrf_pkg;

    localparam int MAX_SIDE = 16;
    localparam int SIDE_W   = $clog2(MAX_SIDE);
    localparam int ADDR_W   = 2 * SIDE_W;
    localparam int DEPTH    = MAX_SIDE * MAX_SIDE;

    localparam int OP_W     = 3;
    localparam int CRD_W    = 4;
    localparam int DATA_W   = 32;
    localparam int SIZE_W   = 5;
    localparam int ORI_W    = 3;
    localparam int CALC_W   = (SIDE_W + 1 > SIZE_W) ? SIDE_W + 1 : SIZE_W;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(16);

    localparam logic [OP_W-1:0] OP_LOAD = 3'd0;
    localparam logic [OP_W-1:0] OP_CW   = 3'd1;
    localparam logic [OP_W-1:0] OP_CCW  = 3'd2;
    localparam logic [OP_W-1:0] OP_FLIP = 3'd3;
    localparam logic [OP_W-1:0] OP_READ = 3'd4;

    localparam logic [ORI_W-1:0] OR_SWAP = 3'b001;
    localparam logic [ORI_W-1:0] OR_MROW = 3'b010;
    localparam logic [ORI_W-1:0] OR_MCOL = 3'b100;

    typedef struct packed {
        logic              hit;
        logic [ADDR_W-1:0] addr;
    } t_loc;

endpackage

### sv/smrf_ram.sv
// ----------------------------------------------------------------------------
// smrf_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module smrf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/smrf_map.sv
// ----------------------------------------------------------------------------
// smrf_map
// Maps a view position to a physical store address under the orientation.
// ----------------------------------------------------------------------------
module smrf_map
    import smrf_pkg::*;
(
    input  logic [SIZE_W-1:0] i_size,
    input  logic [ORI_W-1:0]  i_ori,
    input  logic [CRD_W-1:0]  i_row,
    input  logic [CRD_W-1:0]  i_col,
    output t_loc              o_loc
);

    logic [CALC_W-1:0] n;
    logic [CALC_W-1:0] row_x;
    logic [CALC_W-1:0] col_x;
    logic [CALC_W-1:0] x0;
    logic [CALC_W-1:0] y0;
    logic [CALC_W-1:0] x1;
    logic [CALC_W-1:0] y1;

    always_comb begin
        n     = (CALC_W'(i_size) > CALC_W'(MAX_SIDE)) ? CALC_W'(MAX_SIDE)
                                                      : CALC_W'(i_size);
        row_x = CALC_W'(i_row);
        col_x = CALC_W'(i_col);
        x0    = ((i_ori & OR_SWAP) != '0) ? col_x : row_x;
        y0    = ((i_ori & OR_SWAP) != '0) ? row_x : col_x;
        x1    = ((i_ori & OR_MROW) != '0) ? n - CALC_W'(1) - x0 : x0;
        y1    = ((i_ori & OR_MCOL) != '0) ? n - CALC_W'(1) - y0 : y0;
        o_loc.hit  = (row_x < n) && (col_x < n);
        o_loc.addr = {x1[SIDE_W-1:0], y1[SIDE_W-1:0]};
    end

endmodule

### sv/square_matrix_rotate_flip_top.sv
// ----------------------------------------------------------------------------
// square_matrix_rotate_flip_top
// N by N matrix store with rotate and flip by orientation remapping.
//
// Channel   Direction  Signals                     Contents
// s_axis    in         tvalid tready tdata tuser   tdata: row, col, value
//                                                  tuser: operation
// m_axis    out        tvalid tready tdata         tdata: read_value
// cfg       in         valid ready data            size
//
// One transaction is accepted per cycle while the input is not stalled;
// rotations and flips only update the orientation register. A read answers
// through the registered memory read and then the output register. Reset
// clears the orientation and sets the size to sixteen; the matrix store is
// not cleared. When the output register is full and stalled while a read
// waits in the memory stage, the input stalls.
// ----------------------------------------------------------------------------
module square_matrix_rotate_flip_top
    import smrf_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [39:0]            i_s_axis_tdata,  // row[3:0], col[7:4], value[39:8]
    input  logic [OP_W-1:0]        i_s_axis_tuser,  // operation[2:0]
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [DATA_W-1:0]      o_m_axis_tdata,  // read_value[31:0]
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [SIZE_W-1:0]      i_cfg_data
);

    logic [SIZE_W-1:0] r_size;
    logic [ORI_W-1:0]  r_ori;
    logic [ORI_W-1:0]  n_ori;
    logic              r_pend;
    logic              r_pend_hit;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_data;

    logic              in_acc;
    logic              move;
    logic [OP_W-1:0]   op;
    logic [CRD_W-1:0]  row;
    logic [CRD_W-1:0]  col;
    logic [DATA_W-1:0] value;
    logic              is_read;
    logic              we;
    logic              re;
    logic [DATA_W-1:0] rdata;
    t_loc              loc;

    assign op    = i_s_axis_tuser;
    assign row   = i_s_axis_tdata[3:0];
    assign col   = i_s_axis_tdata[7:4];
    assign value = i_s_axis_tdata[39:8];

    assign o_cfg_ready     = 1'b1;
    assign move            = r_pend && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_pend || !r_out_valid || i_m_axis_tready;
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign is_read         = in_acc && (op == OP_READ);
    assign we              = in_acc && (op == OP_LOAD) && loc.hit;
    assign re              = is_read && loc.hit;

    smrf_map u_map (
        .i_size (r_size),
        .i_ori  (r_ori),
        .i_row  (row),
        .i_col  (col),
        .o_loc  (loc)
    );

    smrf_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (loc.addr),
        .i_wdata (value),
        .i_re    (re),
        .i_raddr (loc.addr),
        .o_rdata (rdata)
    );

    always_comb begin
        n_ori = r_ori;
        if (in_acc) begin
            case (op)
                OP_CW: begin
                    n_ori = ((r_ori & OR_SWAP) != '0) ? r_ori ^ (OR_SWAP | OR_MCOL)
                                                      : r_ori ^ (OR_SWAP | OR_MROW);
                end
                OP_CCW: begin
                    n_ori = ((r_ori & OR_SWAP) != '0) ? r_ori ^ (OR_SWAP | OR_MROW)
                                                      : r_ori ^ (OR_SWAP | OR_MCOL);
                end
                OP_FLIP: begin
                    n_ori = ((r_ori & OR_SWAP) != '0) ? r_ori ^ OR_MCOL
                                                      : r_ori ^ OR_MROW;
                end
                default: begin
                    n_ori = r_ori;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size      <= SIZE_RESET;
            r_ori       <= '0;
            r_pend      <= 1'b0;
            r_pend_hit  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_ori <= n_ori;
            if (i_cfg_valid) begin
                r_size <= i_cfg_data;
            end
            if (is_read) begin
                r_pend     <= 1'b1;
                r_pend_hit <= loc.hit;
            end else if (move) begin
                r_pend <= 1'b0;
            end
            if (move) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out_data <= r_pend_hit ? rdata : '0;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    a_no_we_re: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(we && re))
        else $error("Write and read issued to the store in the same cycle.");

    a_read_pends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        is_read |=> r_pend)
        else $error("Accepted read did not reach the memory stage.");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (move && !r_pend_hit) |=> (o_m_axis_tvalid && (o_m_axis_tdata == '0)))
        else $error("Out-of-range read did not return zero.");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_pend && !r_out_valid) |-> o_s_axis_tready)
        else $error("Input stalled while the pipeline was empty.");

endmodule
